// ===== hw/rtl/hmbf_pkg.sv =====
// Package for the HTTP message body framer: payload types, character constants and lookup functions.
`default_nettype none
package hmbf_pkg;
	localparam int LENGTH_BITS_DEF = 32;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_new;
	} in_item_t;

	typedef struct packed {
		logic [7:0] body_byte;
		logic       body_valid;
		logic       header_done;
		logic       message_done;
		logic       parse_error;
	} out_item_t;

	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_SEMI  = 8'h3b;

	// "Content-Length" (14), "Transfer-Encoding" (17), "chunked" (7), "GET" (3)
	localparam logic [8*14-1:0] CL_TEXT = "Content-Length";
	localparam logic [8*17-1:0] TE_TEXT = "Transfer-Encoding";
	localparam logic [8*7-1:0]  CK_TEXT = "chunked";
	localparam logic [8*3-1:0]  GET_TEXT = "GET";

	function automatic logic [7:0] cl_char(input logic [4:0] i);
		cl_char = (i < 5'd14) ? CL_TEXT[8*(13-i) +: 8] : 8'h00;
	endfunction

	function automatic logic [7:0] te_char(input logic [4:0] i);
		te_char = (i < 5'd17) ? TE_TEXT[8*(16-i) +: 8] : 8'h00;
	endfunction

	function automatic logic [7:0] ck_char(input logic [4:0] i);
		ck_char = (i < 5'd7) ? CK_TEXT[8*(6-i) +: 8] : 8'h00;
	endfunction

	function automatic logic [7:0] get_char(input logic [1:0] i);
		get_char = (i < 2'd3) ? GET_TEXT[8*(2-i) +: 8] : 8'h00;
	endfunction

	// returns {valid, value}
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39)      hex_val = {1'b1, c[3:0]};
		else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
			hex_val = {1'b1, c[3:0] + 4'd9};
		else                               hex_val = 5'd0;
	endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/http_message_body_framer.sv =====
// HTTP message body framer top level.
//
// Takes one message byte per transaction and returns one result per byte. All parse
// state is updated from the input byte in one combinational pass into a result register,
// so the block sustains one byte per clock with back-to-back transactions while the
// consumer accepts results. The output register is only refilled when it is empty or
// being drained, so a stalled consumer holds the input channel. The user must write
// message_kind through cfg_we/cfg_data while the block is idle; it does not enforce this.
`default_nettype none
module http_message_body_framer #(
	parameter int LENGTH_BITS = hmbf_pkg::LENGTH_BITS_DEF
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     cfg_we,
	input  wire                     cfg_data,
	input  wire                     in_valid,
	output logic                    in_ready,
	input  hmbf_pkg::in_item_t      in_data,
	output logic                    out_valid,
	input  wire                     out_ready,
	output hmbf_pkg::out_item_t     out_data
);
	typedef enum logic [1:0] {PH_HEAD, PH_BODY, PH_DONE} phase_t;
	typedef enum logic [2:0] {LM_NAME, LM_COLON, LM_VCL, LM_VTE, LM_VOTHER} lm_t;
	typedef enum logic [1:0] {MODE_RAW, MODE_LEN, MODE_CHUNK} mode_t;
	typedef enum logic [2:0] {CK_SIZE0, CK_SIZE, CK_EXT, CK_LF, CK_DATA, CK_SKIP1,
		CK_SKIP2} ck_t;

	localparam logic [LENGTH_BITS-1:0] LMAX = '1;
	localparam logic [LENGTH_BITS-1:0] LDIV10 = LMAX / 10;
	localparam logic [3:0] LREM10 = 4'(LMAX % 10);

	logic       kind_q;
	phase_t     phase_q, phase_d;
	lm_t        lm_q, lm_d;
	mode_t      mode_q, mode_d;
	ck_t        ck_q, ck_d;
	logic       crlf_q, crlf_d;
	logic [LENGTH_BITS-1:0] len_q, len_d, cnt_q, cnt_d, crem_q, crem_d, acc_q, acc_d;
	logic have_len_q, have_len_d, chunked_q, chunked_d, get_q, get_d, err_q, err_d;
	logic hdone_q, hdone_d, first_q, first_d, empty_q, empty_d, mend_q, mend_d;
	logic gbad_q, gbad_d, clok_q, clok_d, teok_q, teok_d, tegood_q, tegood_d;
	logic dig_q, dig_d, stop_q, stop_d, over_q, over_d;
	logic [1:0] gpos_q, gpos_d;
	logic [4:0] npos_q, npos_d, tpos_q, tpos_d;
	logic valid_d;
	logic [7:0] c;
	logic [4:0] hx;
	logic take;

	assign in_ready = !out_valid || out_ready;
	assign take = in_valid && in_ready;
	assign c = in_data.data_byte;
	assign hx = hmbf_pkg::hex_val(c);

	always_comb begin
		phase_d = phase_q; lm_d = lm_q; mode_d = mode_q; ck_d = ck_q; crlf_d = crlf_q;
		len_d = len_q; cnt_d = cnt_q; crem_d = crem_q; acc_d = acc_q;
		have_len_d = have_len_q; chunked_d = chunked_q; get_d = get_q; err_d = err_q;
		hdone_d = hdone_q; first_d = first_q; empty_d = empty_q; mend_d = mend_q;
		gbad_d = gbad_q; clok_d = clok_q; teok_d = teok_q; tegood_d = tegood_q;
		dig_d = dig_q; stop_d = stop_q; over_d = over_q; gpos_d = gpos_q;
		npos_d = npos_q; tpos_d = tpos_q;
		valid_d = 1'b0;
		if (in_data.start_new) begin
			phase_d = PH_HEAD; crlf_d = 1'b0; ck_d = CK_SIZE0; mode_d = MODE_RAW;
			len_d = '0; cnt_d = '0; crem_d = '0; have_len_d = 1'b0; chunked_d = 1'b0;
			get_d = 1'b0; err_d = 1'b0; hdone_d = 1'b0; first_d = 1'b1; mend_d = 1'b0;
			gbad_d = 1'b0; gpos_d = '0;
			lm_d = LM_NAME; empty_d = 1'b1; npos_d = '0; tpos_d = '0; clok_d = 1'b1;
			teok_d = 1'b1; tegood_d = 1'b1; dig_d = 1'b0; stop_d = 1'b0; over_d = 1'b0;
			acc_d = '0;
		end
		if (!err_d) begin
			unique case (phase_d)
				PH_HEAD: begin
					logic ch_en;
					logic [7:0] cc;
					logic line_end;
					ch_en = 1'b0; cc = c; line_end = 1'b0;
					if (crlf_d) begin
						crlf_d = 1'b0;
						if (c == hmbf_pkg::CH_LF) line_end = 1'b1;
						else begin
							// pending lone CR is content; this byte is also handled below
							cc = hmbf_pkg::CH_CR; ch_en = 1'b1;
						end
					end
					// two content bytes at most per cycle: the held CR, then c
					for (int k = 0; k < 2; k++) begin
						logic en;
						logic [7:0] b;
						en = (k == 0) ? ch_en : (!line_end && c != hmbf_pkg::CH_CR);
						b = (k == 0) ? cc : c;
						if (en) begin
							empty_d = 1'b0;
							if (first_d) begin
								if (!mend_d) begin
									if (b == hmbf_pkg::CH_SP) mend_d = 1'b1;
									else if (gpos_d < 2'd3 && b == hmbf_pkg::get_char(gpos_d))
										gpos_d = gpos_d + 2'd1;
									else gbad_d = 1'b1;
								end
							end else begin
								case (lm_d)
									LM_NAME: begin
										if (b == hmbf_pkg::CH_COLON) lm_d = LM_COLON;
										else begin
											if (!(npos_d < 5'd14 && b == hmbf_pkg::cl_char(npos_d)))
												clok_d = 1'b0;
											if (!(npos_d < 5'd17 && b == hmbf_pkg::te_char(npos_d)))
												teok_d = 1'b0;
											if (npos_d < 5'd31) npos_d = npos_d + 5'd1;
										end
									end
									LM_COLON: begin
										if (b == hmbf_pkg::CH_SP) begin
											if (clok_d && npos_d == 5'd14) lm_d = LM_VCL;
											else if (teok_d && npos_d == 5'd17) lm_d = LM_VTE;
											else lm_d = LM_VOTHER;
										end else begin
											clok_d = 1'b0; teok_d = 1'b0;
											if (b != hmbf_pkg::CH_COLON) lm_d = LM_NAME;
										end
									end
									LM_VCL: begin
										if (!stop_d) begin
											if (b >= 8'h30 && b <= 8'h39) begin
												if (acc_d > LDIV10 || (acc_d == LDIV10 && b[3:0] > LREM10))
													over_d = 1'b1;
												else acc_d = LENGTH_BITS'(acc_d * 10)
													+ LENGTH_BITS'(b[3:0]);
												dig_d = 1'b1;
											end else if (!dig_d && (b == hmbf_pkg::CH_SP ||
												b == hmbf_pkg::CH_TAB)) begin
											end else stop_d = 1'b1;
										end
									end
									LM_VTE: begin
										if (!(tpos_d < 5'd7 && b == hmbf_pkg::ck_char(tpos_d)))
											tegood_d = 1'b0;
										if (tpos_d < 5'd31) tpos_d = tpos_d + 5'd1;
									end
									default: ;
								endcase
							end
						end
					end
					if (!line_end && c == hmbf_pkg::CH_CR) crlf_d = 1'b1;
					if (line_end) begin
						logic clr;
						clr = 1'b1;
						if (first_d) begin
							first_d = 1'b0;
							get_d = (gpos_d == 2'd3) && !gbad_d;
						end else if (empty_d) begin
							clr = 1'b0;
							hdone_d = 1'b1;
							if (kind_q && get_d) phase_d = PH_DONE;
							else if (have_len_d) begin
								mode_d = MODE_LEN;
								phase_d = (len_d == '0) ? PH_DONE : PH_BODY;
							end else begin
								mode_d = chunked_d ? MODE_CHUNK : MODE_RAW;
								phase_d = PH_BODY;
							end
						end else if (lm_d == LM_VCL) begin
							if (!dig_d || over_d) err_d = 1'b1;
							else begin len_d = acc_d; have_len_d = 1'b1; end
						end else if (lm_d == LM_VTE) begin
							chunked_d = tegood_d && tpos_d == 5'd7;
						end
						if (clr) begin
							lm_d = LM_NAME; empty_d = 1'b1; npos_d = '0; tpos_d = '0;
							clok_d = 1'b1; teok_d = 1'b1; tegood_d = 1'b1; dig_d = 1'b0;
							stop_d = 1'b0; over_d = 1'b0; acc_d = '0;
						end
					end
				end
				PH_BODY: begin
					if (mode_d == MODE_CHUNK) begin
						case (ck_d)
							CK_SIZE0: begin
								if (!hx[4]) err_d = 1'b1;
								else begin crem_d = LENGTH_BITS'(hx[3:0]); ck_d = CK_SIZE; end
							end
							CK_SIZE: begin
								if (hx[4]) begin
									if (crem_d[LENGTH_BITS-1 -: 4] != 4'd0) err_d = 1'b1;
									else crem_d = {crem_d[LENGTH_BITS-5:0], hx[3:0]};
								end else if (c == hmbf_pkg::CH_CR) ck_d = CK_LF;
								else if (c == hmbf_pkg::CH_SEMI || c == hmbf_pkg::CH_SP ||
									c == hmbf_pkg::CH_TAB) ck_d = CK_EXT;
								else err_d = 1'b1;
							end
							CK_EXT: if (c == hmbf_pkg::CH_CR) ck_d = CK_LF;
							CK_LF: begin
								if (c != hmbf_pkg::CH_LF) err_d = 1'b1;
								else if (crem_d == '0) phase_d = PH_DONE;
								else ck_d = CK_DATA;
							end
							CK_DATA: begin
								crem_d = crem_d - 1'b1;
								if (crem_d == '0) ck_d = CK_SKIP1;
								valid_d = 1'b1;
							end
							CK_SKIP1: ck_d = CK_SKIP2;
							default: begin ck_d = CK_SIZE0; crem_d = '0; end
						endcase
					end else if (mode_d == MODE_LEN) begin
						valid_d = 1'b1;
						cnt_d = cnt_d + 1'b1;
						if (cnt_d >= len_d) phase_d = PH_DONE;
					end else valid_d = 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= 1'b0; phase_q <= PH_HEAD; lm_q <= LM_NAME; mode_q <= MODE_RAW;
			ck_q <= CK_SIZE0; crlf_q <= 1'b0; len_q <= '0; cnt_q <= '0; crem_q <= '0;
			acc_q <= '0; have_len_q <= 1'b0; chunked_q <= 1'b0; get_q <= 1'b0;
			err_q <= 1'b0; hdone_q <= 1'b0; first_q <= 1'b1; empty_q <= 1'b1;
			mend_q <= 1'b0; gbad_q <= 1'b0; clok_q <= 1'b1; teok_q <= 1'b1;
			tegood_q <= 1'b1; dig_q <= 1'b0; stop_q <= 1'b0; over_q <= 1'b0;
			gpos_q <= '0; npos_q <= '0; tpos_q <= '0; out_valid <= 1'b0;
		end else begin
			if (cfg_we) kind_q <= cfg_data;
			if (take) begin
				phase_q <= phase_d; lm_q <= lm_d; mode_q <= mode_d; ck_q <= ck_d;
				crlf_q <= crlf_d; len_q <= len_d; cnt_q <= cnt_d; crem_q <= crem_d;
				acc_q <= acc_d; have_len_q <= have_len_d; chunked_q <= chunked_d;
				get_q <= get_d; err_q <= err_d; hdone_q <= hdone_d; first_q <= first_d;
				empty_q <= empty_d; mend_q <= mend_d; gbad_q <= gbad_d; clok_q <= clok_d;
				teok_q <= teok_d; tegood_q <= tegood_d; dig_q <= dig_d; stop_q <= stop_d;
				over_q <= over_d; gpos_q <= gpos_d; npos_q <= npos_d; tpos_q <= tpos_d;
				out_valid <= 1'b1;
			end else if (out_ready) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_data.body_byte    <= valid_d ? c : 8'h00;
			out_data.body_valid   <= valid_d;
			out_data.header_done  <= hdone_d;
			out_data.message_done <= (phase_d == PH_DONE);
			out_data.parse_error  <= err_d;
		end
	end

`ifndef SYNTH
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		err_q && take && !in_data.start_new |=> err_q)
		else $error("error flag cleared without restart");
	a_body_after_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		take && valid_d |-> hdone_d)
		else $error("body byte before header end");
	a_done_no_body: assert property (@(posedge clk) disable iff (!arst_n)
		take && phase_q == PH_DONE && !in_data.start_new |-> !valid_d)
		else $error("body byte after message end");
`endif
endmodule
`default_nettype wire
